// ===== rtl/core/bst_pkg.sv =====
// Token codes, keyword table and word classification shared by the tokenizer.
`timescale 1ns / 1ps

package bst_pkg;

    // Token classes carried on the result word.
    typedef enum logic [5:0] {
        KIND_EOF     = 6'd0,
        KIND_NUM     = 6'd1,
        KIND_BADNUM  = 6'd2,
        KIND_VAR     = 6'd3,
        KIND_PRINT   = 6'd4,
        KIND_IF      = 6'd5,
        KIND_THEN    = 6'd6,
        KIND_GOTO    = 6'd7,
        KIND_INPUT   = 6'd8,
        KIND_LET     = 6'd9,
        KIND_GOSUB   = 6'd10,
        KIND_RETURN  = 6'd11,
        KIND_CLEAR   = 6'd12,
        KIND_LIST    = 6'd13,
        KIND_RUN     = 6'd14,
        KIND_END     = 6'd15,
        KIND_BADID   = 6'd16,
        KIND_UNDEF   = 6'd17,
        KIND_STR     = 6'd18,
        KIND_BADSTR  = 6'd19,
        KIND_EQ      = 6'd20,
        KIND_LT      = 6'd21,
        KIND_LE      = 6'd22,
        KIND_GT      = 6'd23,
        KIND_GE      = 6'd24,
        KIND_NE      = 6'd25,
        KIND_COMMA   = 6'd26,
        KIND_NL      = 6'd27,
        KIND_LP      = 6'd28,
        KIND_RP      = 6'd29,
        KIND_PLUS    = 6'd30,
        KIND_MINUS   = 6'd31,
        KIND_STAR    = 6'd32,
        KIND_SLASH   = 6'd33
    } kind_t;

    // Word letters: the first letter sits in the top byte, index 5.
    typedef logic [5:0][7:0] word_t;

    localparam int KW_COUNT = 12;
    localparam int WORD_MAX = 6;

    localparam word_t KW_TEXT [KW_COUNT] = '{
        {"PRINT", 8'h00},
        {"IF", 32'h0},
        {"THEN", 16'h0},
        {"GOTO", 16'h0},
        {"INPUT", 8'h00},
        {"LET", 24'h0},
        {"GOSUB", 8'h00},
        {"RETURN"},
        {"CLEAR", 8'h00},
        {"LIST", 16'h0},
        {"RUN", 24'h0},
        {"END", 24'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd5, 3'd6, 3'd5, 3'd4, 3'd3, 3'd3
    };

    // Classify an uppercase word. Letters past the count are don't-care, so
    // they are masked before the parallel keyword compare.
    function automatic kind_t word_kind(word_t letters, logic [2:0] count);
        word_t key;
        kind_t k;
        key = '0;
        for (int j = 0; j < WORD_MAX; j++) begin
            if (3'(j) < count) begin
                key[WORD_MAX - 1 - j] = letters[WORD_MAX - 1 - j];
            end
        end
        k = KIND_UNDEF;
        if (count == 3'd1) begin
            k = KIND_VAR;
        end
        else if (count <= 3'(WORD_MAX)) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (KW_LEN[i] == count && KW_TEXT[i] == key) begin
                    k = kind_t'(6'(KIND_PRINT) + 6'(i));
                end
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/basic_source_tokenizer.sv =====
// Top level of the BASIC source tokenizer: byte input, token output.
`timescale 1ns / 1ps
//
//  Channel  Dir  Word                                     Handshake
//  s_*      in   tdata[7:0] char, tlast end of source     s_tvalid & s_tready
//  m_*      out  tuser kind, tdata start/length, tlast    m_tvalid & m_tready
//
//  A byte waits in the input register until it loads; its tokens, none up to
//  three, then load together into a three-slot result buffer.
//  Sustained rate is one byte per cycle while each byte yields at most one
//  token and the output is ready; a byte with more tokens holds the input
//  until the one-token-per-cycle output drains the buffer to its last token.
//  Reset clears the mode, position, token mark, letter count, the input valid
//  flag and the buffer count.
//  A stall on the output holds the buffer; the input register keeps taking
//  a byte while the buffer still drains its last token.

module basic_source_tokenizer #(
    parameter int POS_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [5:0]  m_tuser,   // [5:0] kind code
    output logic        m_tlast    // last_of_run
);

    import bst_pkg::*;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_NUM  = 3'd1,
        MODE_WORD = 3'd2,
        MODE_STR  = 3'd3,
        MODE_LT   = 3'd4,
        MODE_GT   = 3'd5,
        MODE_CR   = 3'd6
    } mode_t;

    // Character classes.
    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return is_upper(c) || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == 8'h20 || c == 8'h0C || c == 8'h09 || c == 8'h0B;
    endfunction

    function automatic logic is_strch(logic [7:0] c);
        return c == 8'h20 || c == 8'h21 || (c >= 8'h23 && c <= 8'h7E);
    endfunction

    // Token length wraps at the position width before it is cut to 16 bits.
    function automatic logic [15:0] span(pos_t first, pos_t stop);
        pos_t d;
        d = stop - first;
        return 16'(d);
    endfunction

    // Kind of a pending token that is closed without taking a byte.
    function automatic kind_t close_kind(mode_t m, word_t letters, logic [2:0] count);
        kind_t k;
        case (m)
            MODE_NUM:  k = KIND_NUM;
            MODE_WORD: k = word_kind(letters, count);
            MODE_STR:  k = KIND_BADSTR;
            MODE_LT:   k = KIND_LT;
            MODE_GT:   k = KIND_GT;
            MODE_CR:   k = KIND_NL;
            default:   k = KIND_UNDEF;
        endcase
        return k;
    endfunction

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Lexer state.
    mode_t      mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       mark_reg, mark_next;
    word_t      letters_reg, letters_next;
    logic [2:0] count_reg, count_next;

    // Result buffer; slot 0 drives the output.
    kind_t       slot_kind_reg [3];
    logic [15:0] slot_start_reg [3];
    logic [15:0] slot_len_reg [3];
    logic [1:0]  cnt_reg;

    // Tokens produced by the byte in the input register.
    kind_t       res_kind [3];
    logic [15:0] res_start [3];
    logic [15:0] res_len [3];
    logic [1:0]  res_cnt;

    logic load;
    logic take;
    pos_t cur_pos;
    pos_t nxt_pos;
    logic consumed;
    logic close_old;
    kind_t single_kind;

    assign take     = m_tvalid && m_tready;
    assign load     = in_valid_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_tready));
    assign s_tready = !in_valid_reg || load;

    assign cur_pos = pos_reg;
    assign nxt_pos = pos_reg + pos_t'(1);

    // Single-byte tokens started from idle.
    always_comb
    begin
        case (in_byte_reg)
            "=":     single_kind = KIND_EQ;
            ",":     single_kind = KIND_COMMA;
            8'h0A:   single_kind = KIND_NL;
            "(":     single_kind = KIND_LP;
            ")":     single_kind = KIND_RP;
            "+":     single_kind = KIND_PLUS;
            "-":     single_kind = KIND_MINUS;
            "*":     single_kind = KIND_STAR;
            "/":     single_kind = KIND_SLASH;
            default: single_kind = KIND_UNDEF;
        endcase
    end

    // Scan one byte: offer it to the pending token, rescan from idle if it
    // does not continue, then flush and close the source on the end flag.
    always_comb
    begin
        mode_next    = mode_reg;
        mark_next    = mark_reg;
        letters_next = letters_reg;
        count_next   = count_reg;
        pos_next     = nxt_pos;
        consumed     = 1'b0;
        close_old    = 1'b0;
        res_cnt      = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res_kind[i]  = KIND_EOF;
            res_start[i] = '0;
            res_len[i]   = '0;
        end

        case (mode_reg)
            MODE_NUM:
            begin
                if (is_digit(in_byte_reg)) begin
                    consumed = 1'b1;
                end
                else if (is_alpha(in_byte_reg)) begin
                    res_kind[res_cnt]  = KIND_BADNUM;
                    res_start[res_cnt] = 16'(mark_reg);
                    res_len[res_cnt]   = span(mark_reg, nxt_pos);
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = MODE_IDLE;
                    consumed           = 1'b1;
                end
                else begin
                    close_old = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_upper(in_byte_reg)) begin
                    if (count_reg < 3'(WORD_MAX)) begin
                        letters_next[3'(WORD_MAX - 1) - count_reg] = in_byte_reg;
                    end
                    if (count_reg != 3'd7) begin
                        count_next = count_reg + 3'd1;
                    end
                    consumed = 1'b1;
                end
                else if (is_digit(in_byte_reg)) begin
                    res_kind[res_cnt]  = KIND_BADID;
                    res_start[res_cnt] = 16'(mark_reg);
                    res_len[res_cnt]   = span(mark_reg, nxt_pos);
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = MODE_IDLE;
                    consumed           = 1'b1;
                end
                else begin
                    close_old = 1'b1;
                end
            end
            MODE_STR:
            begin
                if (is_strch(in_byte_reg)) begin
                    consumed = 1'b1;
                end
                else if (in_byte_reg == "\"") begin
                    res_kind[res_cnt]  = KIND_STR;
                    res_start[res_cnt] = 16'(mark_reg);
                    res_len[res_cnt]   = span(mark_reg, nxt_pos);
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = MODE_IDLE;
                    consumed           = 1'b1;
                end
                else begin
                    close_old = 1'b1;
                end
            end
            MODE_LT, MODE_GT:
            begin
                if (in_byte_reg == "=" ||
                    (mode_reg == MODE_LT && in_byte_reg == ">") ||
                    (mode_reg == MODE_GT && in_byte_reg == "<")) begin
                    if (in_byte_reg == "=") begin
                        res_kind[res_cnt] = (mode_reg == MODE_LT) ? KIND_LE : KIND_GE;
                    end
                    else begin
                        res_kind[res_cnt] = KIND_NE;
                    end
                    res_start[res_cnt] = 16'(mark_reg);
                    res_len[res_cnt]   = span(mark_reg, nxt_pos);
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = MODE_IDLE;
                    consumed           = 1'b1;
                end
                else begin
                    close_old = 1'b1;
                end
            end
            MODE_CR:
            begin
                if (in_byte_reg == 8'h0A) begin
                    res_kind[res_cnt]  = KIND_NL;
                    res_start[res_cnt] = 16'(mark_reg);
                    res_len[res_cnt]   = span(mark_reg, nxt_pos);
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = MODE_IDLE;
                    consumed           = 1'b1;
                end
                else begin
                    close_old = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // The pending token ends just before this byte.
        if (close_old) begin
            res_kind[res_cnt]  = close_kind(mode_reg, letters_reg, count_reg);
            res_start[res_cnt] = 16'(mark_reg);
            res_len[res_cnt]   = span(mark_reg, cur_pos);
            res_cnt            = res_cnt + 2'd1;
            mode_next          = MODE_IDLE;
        end

        // Start a new token from idle.
        if (!consumed && !is_blank(in_byte_reg)) begin
            mark_next = cur_pos;
            if (is_digit(in_byte_reg)) begin
                mode_next = MODE_NUM;
            end
            else if (is_upper(in_byte_reg)) begin
                letters_next[WORD_MAX - 1] = in_byte_reg;
                count_next                 = 3'd1;
                mode_next                  = MODE_WORD;
            end
            else if (in_byte_reg == "\"") begin
                mode_next = MODE_STR;
            end
            else if (in_byte_reg == "<") begin
                mode_next = MODE_LT;
            end
            else if (in_byte_reg == ">") begin
                mode_next = MODE_GT;
            end
            else if (in_byte_reg == 8'h0D) begin
                mode_next = MODE_CR;
            end
            else begin
                res_kind[res_cnt]  = single_kind;
                res_start[res_cnt] = 16'(cur_pos);
                res_len[res_cnt]   = span(cur_pos, nxt_pos);
                res_cnt            = res_cnt + 2'd1;
            end
        end

        // End of source: flush the pending token, then the end-of-file token.
        if (in_last_reg) begin
            if (mode_next != MODE_IDLE) begin
                res_kind[res_cnt]  = close_kind(mode_next, letters_next, count_next);
                res_start[res_cnt] = 16'(mark_next);
                res_len[res_cnt]   = span(mark_next, nxt_pos);
                res_cnt            = res_cnt + 2'd1;
            end
            res_kind[res_cnt]  = KIND_EOF;
            res_start[res_cnt] = 16'(nxt_pos);
            res_len[res_cnt]   = '0;
            res_cnt            = res_cnt + 2'd1;
            pos_next           = '0;
            mode_next          = MODE_IDLE;
        end
    end

    // Input register, lexer state and result buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            mark_reg     <= '0;
            count_reg    <= 3'd0;
            cnt_reg      <= 2'd0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
                in_last_reg  <= s_tlast;
            end
            else if (load) begin
                in_valid_reg <= 1'b0;
            end

            if (load) begin
                mode_reg    <= mode_next;
                pos_reg     <= pos_next;
                mark_reg    <= mark_next;
                letters_reg <= letters_next;
                count_reg   <= count_next;
                for (int i = 0; i < 3; i++) begin
                    slot_kind_reg[i]  <= res_kind[i];
                    slot_start_reg[i] <= res_start[i];
                    slot_len_reg[i]   <= res_len[i];
                end
                cnt_reg <= res_cnt;
            end
            else if (take) begin
                for (int i = 0; i < 2; i++) begin
                    slot_kind_reg[i]  <= slot_kind_reg[i + 1];
                    slot_start_reg[i] <= slot_start_reg[i + 1];
                    slot_len_reg[i]   <= slot_len_reg[i + 1];
                end
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Output word from the head slot.
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tlast  = cnt_reg == 2'd1;
    assign m_tuser  = slot_kind_reg[0];
    assign m_tdata  = {slot_len_reg[0], slot_start_reg[0]};

    // The end flag always yields at least the end-of-file token.
    assert property (@(posedge clk) disable iff (!rst_n)
        load && in_last_reg |-> res_cnt != 2'd0)
        else $error("end of source produced no token");

    // After the end flag the position and mode are back at their start.
    assert property (@(posedge clk) disable iff (!rst_n)
        load && in_last_reg |=> pos_reg == '0 && mode_reg == MODE_IDLE && m_tvalid)
        else $error("lexer did not return to start after end of source");

    // Lexer state only moves when a byte is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(pos_reg) && $stable(mode_reg))
        else $error("lexer state changed without a byte");

    // A taken word without a new load removes exactly one token.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !load |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("result buffer count slipped");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the BASIC source tokenizer: byte stream in, tokens out.
`timescale 1ns / 1ps

module tb_top;

    import bst_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 350;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // One token as it leaves the block.
    typedef struct {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Scanner state of the predictor.
    typedef enum logic [2:0] {
        LX_IDLE, LX_NUM, LX_WORD, LX_STR, LX_LT, LX_GT, LX_CR
    } lex_mode_t;

    // Predicts the tokens of each accepted byte and checks the block's output.
    class token_scoreboard;
        token_t      tokens_due[$];
        token_t      step_tokens[$];
        lex_mode_t   mode;
        logic [15:0] pos;
        logic [15:0] mark;
        logic [7:0]  letters[6];
        int unsigned count;
        int          errors;
        int          checked;
        int          sources_ended;

        function new();
            mode = LX_IDLE;
            pos = '0;
            mark = '0;
            count = 0;
            errors = 0;
            checked = 0;
            sources_ended = 0;
        endfunction

        function string kw_text(int i);
            case (i)
                0: return "PRINT";
                1: return "IF";
                2: return "THEN";
                3: return "GOTO";
                4: return "INPUT";
                5: return "LET";
                6: return "GOSUB";
                7: return "RETURN";
                8: return "CLEAR";
                9: return "LIST";
                10: return "RUN";
                default: return "END";
            endcase
        endfunction

        function int outstanding();
            return tokens_due.size();
        endfunction

        static function bit is_digit(logic [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        static function bit is_upper(logic [7:0] b);
            return b >= CH_UP_A && b <= CH_UP_Z;
        endfunction

        static function bit is_alpha(logic [7:0] b);
            return is_upper(b) || (b >= CH_LO_A && b <= CH_LO_Z);
        endfunction

        static function bit is_blank(logic [7:0] b);
            return b == CH_SPACE || b == CH_FF || b == CH_TAB || b == CH_VT;
        endfunction

        static function bit is_str_char(logic [7:0] b);
            return b == CH_SPACE || b == CH_BANG || (b > CH_QUOTE && b <= CH_TILDE);
        endfunction

        function void put(kind_t k, logic [15:0] first, logic [15:0] stop);
            token_t t;
            t.kind = k;
            t.start = first;
            t.length = stop - first;
            t.last = 1'b0;
            step_tokens.push_back(t);
        endfunction

        // Classify the pending uppercase word.
        function kind_t word_kind();
            string kw;
            bit hit;
            if (count == 1) return KIND_VAR;
            if (count > 6) return KIND_UNDEF;
            for (int i = 0; i < 12; i++) begin
                kw = kw_text(i);
                if (kw.len() == count) begin
                    hit = 1'b1;
                    for (int j = 0; j < count; j++) begin
                        if (kw.getc(j) != letters[j]) hit = 1'b0;
                    end
                    if (hit) return kind_t'(6'(int'(KIND_PRINT) + i));
                end
            end
            return KIND_UNDEF;
        endfunction

        // Close whatever token is pending, ending at position stop.
        function void close_token(logic [15:0] stop);
            case (mode)
                LX_NUM: put(KIND_NUM, mark, stop);
                LX_WORD: put(word_kind(), mark, stop);
                LX_STR: put(KIND_BADSTR, mark, stop);
                LX_LT: put(KIND_LT, mark, stop);
                LX_GT: put(KIND_GT, mark, stop);
                LX_CR: put(KIND_NL, mark, stop);
                default: ;
            endcase
            mode = LX_IDLE;
        endfunction

        // Scan a byte with no token pending.
        function void open_token(logic [7:0] b, logic [15:0] p);
            kind_t k;
            if (is_blank(b)) return;
            mark = p;
            if (is_digit(b)) begin
                mode = LX_NUM;
                return;
            end
            if (is_upper(b)) begin
                letters[0] = b;
                count = 1;
                mode = LX_WORD;
                return;
            end
            case (b)
                CH_QUOTE: mode = LX_STR;
                CH_LT: mode = LX_LT;
                CH_GT: mode = LX_GT;
                CH_CR: mode = LX_CR;
                default: ;
            endcase
            if (mode != LX_IDLE) return;
            case (b)
                CH_EQ: k = KIND_EQ;
                8'h2C: k = KIND_COMMA;
                CH_LF: k = KIND_NL;
                8'h28: k = KIND_LP;
                8'h29: k = KIND_RP;
                8'h2B: k = KIND_PLUS;
                8'h2D: k = KIND_MINUS;
                8'h2A: k = KIND_STAR;
                8'h2F: k = KIND_SLASH;
                default: k = KIND_UNDEF;
            endcase
            put(k, p, p + 16'd1);
        endfunction

        // Offer a byte to the pending token; returns 1 when the byte is taken.
        function bit extend_token(logic [7:0] b, logic [15:0] p);
            logic [15:0] n;
            n = p + 16'd1;
            case (mode)
                LX_NUM: begin
                    if (is_digit(b)) return 1'b1;
                    if (is_alpha(b)) begin
                        put(KIND_BADNUM, mark, n);
                        mode = LX_IDLE;
                        return 1'b1;
                    end
                end
                LX_WORD: begin
                    if (is_upper(b)) begin
                        if (count < 6) letters[count] = b;
                        if (count < 7) count++;
                        return 1'b1;
                    end
                    if (is_digit(b)) begin
                        put(KIND_BADID, mark, n);
                        mode = LX_IDLE;
                        return 1'b1;
                    end
                end
                LX_STR: begin
                    if (is_str_char(b)) return 1'b1;
                    if (b == CH_QUOTE) begin
                        put(KIND_STR, mark, n);
                        mode = LX_IDLE;
                        return 1'b1;
                    end
                end
                LX_LT: begin
                    if (b == CH_EQ || b == CH_GT) begin
                        put(b == CH_EQ ? KIND_LE : KIND_NE, mark, n);
                        mode = LX_IDLE;
                        return 1'b1;
                    end
                end
                LX_GT: begin
                    if (b == CH_EQ || b == CH_LT) begin
                        put(b == CH_EQ ? KIND_GE : KIND_NE, mark, n);
                        mode = LX_IDLE;
                        return 1'b1;
                    end
                end
                LX_CR: begin
                    if (b == CH_LF) begin
                        put(KIND_NL, mark, n);
                        mode = LX_IDLE;
                        return 1'b1;
                    end
                end
                default: return 1'b0;
            endcase
            close_token(p);
            return 1'b0;
        endfunction

        // Note one accepted input word and queue the tokens it causes.
        function void take_byte(logic [7:0] b, logic eos);
            logic [15:0] p;
            p = pos;
            step_tokens.delete();
            if (!extend_token(b, p)) open_token(b, p);
            pos = p + 16'd1;
            if (eos) begin
                close_token(pos);
                put(KIND_EOF, pos, pos);
                pos = '0;
                mode = LX_IDLE;
                sources_ended++;
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
        endfunction

        // Compare one output word with the oldest expected token.
        function void check_token(kind_t k, logic [15:0] first, logic [15:0] len, logic last);
            token_t t;
            if (tokens_due.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected token: kind %0d start %0d length %0d last %0b",
                             k, first, len, last);
                end
                return;
            end
            t = tokens_due.pop_front();
            checked++;
            if (t.kind !== k || t.start !== first || t.length !== len || t.last !== last) begin
                errors++;
                if (errors <= 10) begin
                    $display("Token mismatch: expected kind %0d start %0d length %0d last %0b",
                             t.kind, t.start, t.length, t.last);
                    $display("                actual   kind %0d start %0d length %0d last %0b",
                             k, first, len, last);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard sb = new();
    int  tx_gap_pct = 32;
    int  rx_gap_pct = 32;
    bit  hold_req = 1'b0;
    int  bytes_sent = 0;
    int  quiet_cycles = 0;

    basic_source_tokenizer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d tokens outstanding.", sb.outstanding());
            $display("tb_top failed");
            $finish;
        end
    end

    // Token receiver: checks each accepted word, stalls at random or on a hold-off request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                sb.check_token(kind_t'(m_tuser), m_tdata[15:0], m_tdata[31:16], m_tlast);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= rx_gap_pct);
            end
        end
    end

    // Offer one source byte, with a random gap first, and wait for it to be taken.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eos;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.take_byte(b, eos);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic eos);
        for (int i = 0; i < s.len(); i++) send_byte(s.getc(i), eos && (i == s.len() - 1));
    endtask

    task automatic wait_for_tokens();
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_upper();
        return CH_UP_A + 8'($urandom_range(25));
    endfunction

    // Build and send one random phrase: mostly well-formed tokens, some noise.
    task automatic send_phrase();
        logic [7:0] text[$];
        string      s;
        int         n;
        int         sel;
        logic [7:0] b;
        sel = $urandom_range(11);
        case (sel)
            0, 1: begin
                // Number, sometimes running into a letter.
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) text.push_back(CH_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(3) == 0) begin
                    b = rand_upper();
                    text.push_back($urandom_range(1) ? b : (b | 8'h20));
                end
            end
            2, 3: begin
                // Keyword, now and then clipped or extended.
                s = sb.kw_text($urandom_range(11));
                n = s.len();
                if ($urandom_range(3) == 0) n = $urandom_range(1, s.len());
                for (int i = 0; i < n; i++) text.push_back(s.getc(i));
                if ($urandom_range(5) == 0) text.push_back(rand_upper());
            end
            4: text.push_back(rand_upper());
            5: begin
                // Word cut short by a digit.
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) text.push_back(rand_upper());
                text.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            6: begin
                // Word too long for any keyword.
                n = $urandom_range(7, 9);
                for (int i = 0; i < n; i++) text.push_back(rand_upper());
            end
            7: begin
                // Quoted string; some left open or broken by a control or high byte.
                text.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom_range(32, 126));
                    text.push_back(b == CH_QUOTE ? CH_BANG : b);
                end
                n = $urandom_range(9);
                if (n < 7) begin
                    text.push_back(CH_QUOTE);
                end
                else if (n == 7) begin
                    b = 8'($urandom_range(0, 31));
                    text.push_back($urandom_range(1) ? b : 8'($urandom_range(127, 255)));
                end
            end
            8: begin
                case ($urandom_range(13))
                    0: s = "=";
                    1: s = "<";
                    2: s = ">";
                    3: s = "<=";
                    4: s = ">=";
                    5: s = "<>";
                    6: s = "><";
                    7: s = ",";
                    8: s = "(";
                    9: s = ")";
                    10: s = "+";
                    11: s = "-";
                    12: s = "*";
                    default: s = "/";
                endcase
                for (int i = 0; i < s.len(); i++) text.push_back(s.getc(i));
            end
            9: begin
                case ($urandom_range(3))
                    0: text.push_back(CH_CR);
                    1: text.push_back(CH_LF);
                    2: begin
                        text.push_back(CH_CR);
                        text.push_back(CH_LF);
                    end
                    default: begin
                        text.push_back(CH_LF);
                        text.push_back(CH_CR);
                    end
                endcase
            end
            10: text.push_back(CH_LO_A + 8'($urandom_range(25)));
            default: text.push_back(8'($urandom_range(255)));
        endcase
        // Optional blank separator.
        case ($urandom_range(7))
            0: text.push_back(CH_SPACE);
            1: text.push_back(CH_TAB);
            2: text.push_back(CH_VT);
            3: text.push_back(CH_FF);
            default: ;
        endcase
        n = $urandom_range(24);
        foreach (text[i]) send_byte(text[i], n == 0 && i == text.size() - 1);
    endtask

    task automatic send_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) send_phrase();
    endtask

    // Main sequence.
    initial
    begin
        int directed_end;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, some two-byte operators, newline forms and
        // the special cases of numbers, words and strings.
        send_text("9a", 1'b0);
        send_text("X5", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("<=", 1'b0);
        send_text("><", 1'b0);
        send_text("< ", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_EQ, 1'b0);
        send_text("\"A", 1'b0);
        send_byte(8'h01, 1'b0);
        send_text("=", 1'b1);
        send_text("\"", 1'b1);
        send_text("AB7", 1'b1);
        directed_end = bytes_sent;

        // Random traffic with both sides idling.
        send_random(120);

        // Receiver holds off while bytes keep coming, so the input backs up.
        tx_gap_pct = 0;
        hold_req = 1'b1;
        send_random(40);
        tx_gap_pct = 32;

        // Sender pauses until every token has drained.
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_for_tokens();

        // A stretch at full rate on both sides.
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        send_random(100);
        tx_gap_pct = 32;
        rx_gap_pct = 32;
        send_random(RANDOM_BYTES - 280);
        send_text("END", 1'b1);

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_for_tokens();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d source bytes (%0d directed, the rest random phrases).",
                 bytes_sent, directed_end);
        $display("Checked %0d tokens over %0d ended sources; %0d errors, %0d tokens missing.",
                 sb.checked, sb.sources_ended, sb.errors, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb_top passed");
        end
        else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bst_pkg.sv
rtl/core/basic_source_tokenizer.sv
dv/tb_top.sv
